// ===== hdl/salru_pkg.sv =====
// Shared constants and types for the set-associative LRU cache lookup.
package salru_pkg;

    localparam int TOTAL_BLOCKS_DEF = 16384;
    localparam int MAX_WAYS_DEF     = 16;
    localparam int TAG_BITS_DEF     = 32;

    localparam int SET_W  = 14;
    localparam int TAG_W  = 32;
    localparam int WAY_W  = 4;
    localparam int CFG_W  = 3;
    localparam int CNT_W  = 32;
    localparam int STAMP_W = 32;

    localparam logic [CFG_W-1:0] WAY_SHIFT_RST = 3'd2;
    localparam logic [CNT_W-1:0] CNT_MAX       = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

endpackage

// ===== hdl/set_assoc_lru_cache_lookup.sv =====
// A bad set index gives its result in the cycle after start; otherwise the ways in use are scanned, then written back.
// One shared tag/stamp compare visits one way per cycle during the scan.
// A new item is accepted only after the write-back; a bad set index frees the block at once.
// Reset: valid bits are swept clear one block per cycle, with busy high throughout the sweep.
// Results are strobed for one cycle; the receiver cannot stall.
module set_assoc_lru_cache_lookup
    import salru_pkg::*;
#(
    parameter int TOTAL_BLOCKS = TOTAL_BLOCKS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int TAG_BITS     = TAG_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic [SET_W-1:0]  i_set_index,
    input  logic [TAG_W-1:0]  i_tag,
    output logic              o_strobe,
    output logic              o_hit,
    output logic [WAY_W-1:0]  o_way,
    output logic              o_replaced,
    output logic              o_bad_set,
    output logic [CNT_W-1:0]  o_hit_total,
    output logic [CNT_W-1:0]  o_miss_total
);

    localparam int AW         = $clog2(TOTAL_BLOCKS);
    localparam int WC         = $clog2(MAX_WAYS + 1);
    localparam int SETS_CLAMP = TOTAL_BLOCKS / MAX_WAYS;

    // block memories
    logic [TAG_BITS-1:0] tag_mem   [TOTAL_BLOCKS];
    logic [STAMP_W-1:0]  stamp_mem [TOTAL_BLOCKS];
    logic                vld_mem   [TOTAL_BLOCKS];

    t_state r_state, n_state;

    logic [CFG_W-1:0]    r_way_shift;
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_base;
    logic [WC-1:0]       r_ways;
    logic [WC-1:0]       r_idx;
    logic [TAG_BITS-1:0] r_tag;

    logic                r_rd_vld;
    logic [WAY_W-1:0]    r_rd_way;
    logic [TAG_BITS-1:0] r_rd_tag;
    logic [STAMP_W-1:0]  r_rd_stamp;
    logic                r_rd_valid;

    logic                r_hit;
    logic [WAY_W-1:0]    r_hit_way;
    logic                r_inv_found;
    logic [WAY_W-1:0]    r_inv_way;
    logic [STAMP_W-1:0]  r_min_stamp;
    logic [WAY_W-1:0]    r_min_way;

    logic [CNT_W-1:0]    r_access_cnt;
    logic [CNT_W-1:0]    r_hit_cnt;
    logic [CNT_W-1:0]    r_miss_cnt;

    logic                r_out_stb;
    logic                r_out_hit;
    logic [WAY_W-1:0]    r_out_way;
    logic                r_out_repl;
    logic                r_out_bad;

    // accept-side decode
    logic                accept;
    logic [7:0]          ways_pow;
    logic                ways_clamp;
    logic [WC-1:0]       ways_eff;
    logic [31:0]         sets_eff;
    logic                bad_set;
    logic [31:0]         base_prod;
    logic [TAG_BITS-1:0] tag_in;

    // scan and write-back controls
    logic                issue;
    logic                last_eval;
    logic [AW-1:0]       rd_addr;
    logic [WAY_W-1:0]    pick;
    logic                repl;
    logic [AW-1:0]       wr_addr;
    logic                mem_wr;
    logic                tag_wr;
    logic                vld_wr_data;

    always_comb begin
        accept     = start && !busy;
        ways_pow   = 8'(1) << r_way_shift;
        ways_clamp = ways_pow > 8'(MAX_WAYS);
        ways_eff   = ways_clamp ? WC'(MAX_WAYS) : WC'(ways_pow);
        sets_eff   = ways_clamp ? 32'(SETS_CLAMP) : (32'(TOTAL_BLOCKS) >> r_way_shift);
        bad_set    = 32'(i_set_index) >= sets_eff;
        base_prod  = 32'(i_set_index) * 32'(ways_eff);
        tag_in     = TAG_BITS'({32'd0, i_tag});
    end

    always_comb begin
        issue     = (r_state == ST_SCAN) && (r_idx < r_ways);
        last_eval = (r_state == ST_SCAN) && r_rd_vld && (r_idx == r_ways);
        rd_addr   = r_base + AW'(r_idx);
        repl      = !r_hit && !r_inv_found;
        if (r_hit) begin
            pick = r_hit_way;
        end else if (r_inv_found) begin
            pick = r_inv_way;
        end else begin
            pick = r_min_way;
        end
    end

    // memory port muxing: clear sweep or write-back of the chosen way
    always_comb begin
        mem_wr      = 1'b0;
        tag_wr      = 1'b0;
        vld_wr_data = 1'b0;
        wr_addr     = r_base + AW'(pick);
        unique case (r_state)
            ST_CLEAR: begin
                mem_wr  = 1'b1;
                wr_addr = r_clr_addr;
            end
            ST_WRITE: begin
                mem_wr      = 1'b1;
                tag_wr      = !r_hit;
                vld_wr_data = 1'b1;
            end
            default: begin
                mem_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            vld_mem[wr_addr] <= vld_wr_data;
        end
        r_rd_valid <= vld_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tag_wr) begin
            tag_mem[wr_addr] <= r_tag;
        end
        r_rd_tag <= tag_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr && (r_state == ST_WRITE)) begin
            stamp_mem[wr_addr] <= r_access_cnt;
        end
        r_rd_stamp <= stamp_mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(TOTAL_BLOCKS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (accept && !bad_set) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_eval) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_way_shift  <= WAY_SHIFT_RST;
            r_clr_addr   <= '0;
            r_rd_vld     <= 1'b0;
            r_access_cnt <= '0;
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_out_stb    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_way_shift <= i_cfg_wdata;
            end
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_rd_vld  <= issue;
            r_out_stb <= (accept && bad_set) || (r_state == ST_WRITE);
            if (r_state == ST_WRITE) begin
                r_access_cnt <= r_access_cnt + CNT_W'(1);
                if (r_hit) begin
                    if (r_hit_cnt != CNT_MAX) begin
                        r_hit_cnt <= r_hit_cnt + CNT_W'(1);
                    end
                end else if (r_miss_cnt != CNT_MAX) begin
                    r_miss_cnt <= r_miss_cnt + CNT_W'(1);
                end
            end
        end
    end

    // item registers and per-way search
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag       <= tag_in;
            r_base      <= base_prod[AW-1:0];
            r_ways      <= ways_eff;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
            r_hit_way   <= '0;
            r_inv_way   <= '0;
            r_min_way   <= '0;
            r_min_stamp <= '0;
        end else begin
            if (issue) begin
                r_idx    <= r_idx + WC'(1);
                r_rd_way <= WAY_W'(r_idx);
            end
            if ((r_state == ST_SCAN) && r_rd_vld) begin
                if (r_rd_valid && (r_rd_tag == r_tag) && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_way <= r_rd_way;
                end
                if (!r_rd_valid && !r_inv_found) begin
                    r_inv_found <= 1'b1;
                    r_inv_way   <= r_rd_way;
                end
                // strict less keeps the lowest way on a tie
                if (r_rd_valid && ((r_rd_way == '0) || (r_rd_stamp < r_min_stamp))) begin
                    r_min_stamp <= r_rd_stamp;
                    r_min_way   <= r_rd_way;
                end
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (accept && bad_set) begin
            r_out_hit  <= 1'b0;
            r_out_way  <= '0;
            r_out_repl <= 1'b0;
            r_out_bad  <= 1'b1;
        end else if (r_state == ST_WRITE) begin
            r_out_hit  <= r_hit;
            r_out_way  <= pick;
            r_out_repl <= repl;
            r_out_bad  <= 1'b0;
        end
    end

    assign o_strobe     = r_out_stb;
    assign o_hit        = r_out_hit;
    assign o_way        = r_out_way;
    assign o_replaced   = r_out_repl;
    assign o_bad_set    = r_out_bad;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;

endmodule
